@@ design/sfb_pkg.sv @@
// Package for the serpentine LED frame buffer: sizes, mode codes, colour ROM,
// serpentine index remap and the types shared between modules. No dependencies.
package sfb_pkg;

    localparam int LED_COUNT    = 36;
    localparam int ROW_LENGTH   = 12;
    localparam int HALF_ROW     = ROW_LENGTH / 2;
    localparam int ROWS         = (LED_COUNT + ROW_LENGTH - 1) / ROW_LENGTH;
    localparam int ADDR_W       = $clog2(LED_COUNT);
    localparam int CNT_W        = $clog2(LED_COUNT + 2);
    localparam int PALETTE_SIZE = 10;

    localparam logic [2:0] MODE_PAL_MAIN = 3'd0;
    localparam logic [2:0] MODE_PAL_PAT  = 3'd1;
    localparam logic [2:0] MODE_RGB_MAIN = 3'd2;
    localparam logic [2:0] MODE_BRIGHT   = 3'd3;
    localparam logic [2:0] MODE_EMIT     = 3'd4;

    localparam logic [7:0]  BRIGHT_MAX  = 8'd31;
    localparam logic [7:0]  BRIGHT_MARK = 8'hE0;
    localparam logic [31:0] RESET_WORD  = 32'hE200_0000;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } sfb_pos_t;

    typedef struct packed {
        logic              main_en;
        logic              pat_en;
        logic              upd_bright;
        logic [ADDR_W-1:0] addr;
        logic [23:0]       colour;
        logic [7:0]        bright;
    } sfb_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } sfb_rdreq_t;

    function automatic logic [23:0] palette_rom(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = {8'd0,   8'd0,   8'd0};
            4'd1:    c = {8'd2,   8'd0,   8'd255};
            4'd2:    c = {8'h00,  8'h77,  8'hEE};
            4'd3:    c = {8'd254, 8'd127, 8'd45};
            4'd4:    c = {8'd0,   8'd160, 8'd50};
            4'd5:    c = {8'd107, 8'd72,  8'd254};
            4'd6:    c = {8'd24,  8'd74,  8'd254};
            4'd7:    c = {8'd155, 8'd145, 8'd254};
            4'd8:    c = {8'd187, 8'd254, 8'd67};
            4'd9:    c = {8'h55,  8'h00,  8'hBB};
            default: c = 24'd0;
        endcase
        return c;
    endfunction

    // upper half of each row runs backwards
    function automatic sfb_pos_t serp_map(input logic [5:0] li);
        sfb_pos_t   p;
        logic [6:0] lx;
        logic [6:0] col;
        logic [6:0] phys;
        p.hit  = 1'b0;
        p.addr = '0;
        lx     = {1'b0, li};
        col    = '0;
        phys   = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (lx >= 7'(r * ROW_LENGTH) && lx < 7'((r + 1) * ROW_LENGTH)
                && lx < 7'(LED_COUNT))
            begin
                col = lx - 7'(r * ROW_LENGTH);
                if (col >= 7'(HALF_ROW))
                begin
                    col = 7'(ROW_LENGTH - 1 + HALF_ROW) - col;
                end
                phys = 7'(r * ROW_LENGTH) + col;
                if (phys < 7'(LED_COUNT))
                begin
                    p.hit  = 1'b1;
                    p.addr = phys[ADDR_W-1:0];
                end
            end
        end
        return p;
    endfunction

endpackage

@@ design/serpentine_apa102_frame_buffer_core.sv @@
// Top level of the serpentine LED frame buffer: command decode, read-modify-write
// stage with forwarding, two frame stores and the emit sequencer. Uses sfb_pkg.
//
//   channel   direction  signals                                       transaction
//   command   in         start, busy, mode, led_index, palette_index,  start && !busy
//                        level, red, green, blue
//   result    out        strobe, frame_word, last_word                 strobe, one cycle
//   config    in         cfg_we, cfg_wdata (show_pattern)              cfg_we
//
// Write commands: read at acceptance, merge and write back in the cycle after, with
// back-to-back writes to one entry served by a forwarding register. Emit holds busy
// through the start word, one store read per LED and the end word; results follow
// through the s1 and output registers, one per cycle. Reset clears all stores to
// the reset word via valid bits, with no clearing pass. Results cannot be stalled.
module serpentine_apa102_frame_buffer_core
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [5:0]  led_index,
    input  logic [3:0]  palette_index,
    input  logic [7:0]  level,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output logic        strobe,
    output logic [31:0] frame_word,
    output logic        last_word
);

    logic              show_pattern_reg;
    logic              accept;
    sfb_pos_t          pos;
    sfb_wr_t           wr_next;
    sfb_wr_t           s1_reg;
    logic              s1_valid_reg;
    logic [15:0]       prod_b;
    logic [15:0]       prod_g;
    logic [15:0]       prod_r;
    logic [4:0]        sat;
    logic              pal_ok;
    logic              emit_go;
    sfb_rdreq_t        emit_rd;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       main_rd;
    logic [31:0]       pat_rd;
    logic [31:0]       main_old;
    logic [31:0]       pat_old;
    logic [31:0]       main_new;
    logic [31:0]       pat_new;
    logic              main_we;
    logic              pat_we;
    logic              fwd_main_we_reg;
    logic              fwd_pat_we_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [31:0]       fwd_main_reg;
    logic [31:0]       fwd_pat_reg;

    assign accept  = start && !busy;
    assign pos     = serp_map(led_index);
    assign prod_b  = 16'(blue) * 16'(level);
    assign prod_g  = 16'(green) * 16'(level);
    assign prod_r  = 16'(red) * 16'(level);
    assign sat     = (level > BRIGHT_MAX) ? BRIGHT_MAX[4:0] : level[4:0];
    assign pal_ok  = palette_index < 4'(PALETTE_SIZE);
    assign emit_go = accept && (mode == MODE_EMIT);

    always_comb
    begin
        wr_next.main_en    = 1'b0;
        wr_next.pat_en     = 1'b0;
        wr_next.upd_bright = 1'b0;
        wr_next.addr       = pos.addr;
        wr_next.colour     = palette_rom(palette_index);
        wr_next.bright     = BRIGHT_MARK | {3'b000, sat};
        unique case (mode)
            MODE_PAL_MAIN: wr_next.main_en = pos.hit && pal_ok;
            MODE_PAL_PAT:  wr_next.pat_en  = pos.hit && pal_ok;
            MODE_RGB_MAIN:
            begin
                wr_next.main_en = pos.hit;
                wr_next.colour  = {prod_b[7:0], prod_g[7:0], prod_r[7:0]};
            end
            MODE_BRIGHT:
            begin
                wr_next.main_en    = pos.hit;
                wr_next.pat_en     = pos.hit;
                wr_next.upd_bright = 1'b1;
            end
            default: ;
        endcase
    end

    assign rd_en   = emit_rd.en || (accept && (wr_next.main_en || wr_next.pat_en));
    assign rd_addr = emit_rd.en ? emit_rd.addr : pos.addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_pattern_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            fwd_main_we_reg  <= 1'b0;
            fwd_pat_we_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                show_pattern_reg <= cfg_wdata;
            end
            s1_valid_reg    <= accept && (wr_next.main_en || wr_next.pat_en);
            fwd_main_we_reg <= main_we;
            fwd_pat_we_reg  <= pat_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= wr_next;
        end
        fwd_addr_reg <= s1_reg.addr;
        fwd_main_reg <= main_new;
        fwd_pat_reg  <= pat_new;
    end

    // previous write still landing in memory
    assign main_old = (fwd_main_we_reg && fwd_addr_reg == s1_reg.addr) ? fwd_main_reg : main_rd;
    assign pat_old  = (fwd_pat_we_reg && fwd_addr_reg == s1_reg.addr) ? fwd_pat_reg : pat_rd;

    assign main_new = s1_reg.upd_bright ? {s1_reg.bright, main_old[23:0]}
                                        : {main_old[31:24], s1_reg.colour};
    assign pat_new  = s1_reg.upd_bright ? {s1_reg.bright, pat_old[23:0]}
                                        : {pat_old[31:24], s1_reg.colour};
    assign main_we  = s1_valid_reg && s1_reg.main_en;
    assign pat_we   = s1_valid_reg && s1_reg.pat_en;

    sfb_store u_main
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (main_rd),
        .wr_en   (main_we),
        .wr_addr (s1_reg.addr),
        .wr_data (main_new)
    );

    sfb_store u_pattern
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pat_rd),
        .wr_en   (pat_we),
        .wr_addr (s1_reg.addr),
        .wr_data (pat_new)
    );

    sfb_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (emit_go),
        .busy       (busy),
        .rd_req     (emit_rd),
        .rd_data    (show_pattern_reg ? pat_rd : main_rd),
        .strobe     (strobe),
        .frame_word (frame_word),
        .last_word  (last_word)
    );

endmodule

@@ design/sfb_store.sv @@
// One LED frame store: synchronous memory with registered read,
// per-entry valid bits so unwritten entries read as the reset word. Uses sfb_pkg.
module sfb_store
    import sfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data
);

    logic [31:0]          mem [LED_COUNT];
    logic [31:0]          rd_data_reg;
    logic                 rd_valid_reg;
    logic [LED_COUNT-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : RESET_WORD;

endmodule

@@ design/sfb_emit.sv @@
// Frame emission sequencer: start word, one read per LED, end word.
// Uses sfb_pkg; read data comes from the selected store in the cycle after the request.
module sfb_emit
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    output logic        busy,
    output sfb_rdreq_t  rd_req,
    input  logic [31:0] rd_data,
    output logic        strobe,
    output logic [31:0] frame_word,
    output logic        last_word
);

    logic             active_reg;
    logic             active_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             s1_valid_reg;
    logic             s1_data_reg;
    logic             s1_last_reg;
    logic             strobe_reg;
    logic             last_reg;
    logic [31:0]      word_reg;
    logic             is_data;
    logic             is_last;
    logic [CNT_W-1:0] addr_wide;

    assign is_data   = (cnt_reg != '0) && (cnt_reg <= CNT_W'(LED_COUNT));
    assign is_last   = (cnt_reg == CNT_W'(LED_COUNT + 1));
    assign addr_wide = cnt_reg - CNT_W'(1);

    assign rd_req.en   = active_reg && is_data;
    assign rd_req.addr = addr_wide[ADDR_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (active_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
        else if (go)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= active_reg;
            strobe_reg   <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= is_data;
        s1_last_reg <= is_last;
        word_reg    <= s1_data_reg ? rd_data : 32'd0;
        last_reg    <= s1_last_reg;
    end

    assign busy       = active_reg;
    assign strobe     = strobe_reg;
    assign frame_word = word_reg;
    assign last_word  = last_reg;

endmodule
